// ===== sv/i2cdw_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cdw_pkg
// Constants shared by the display write master: bus step codes, control
// bytes, register map and field widths.
// ----------------------------------------------------------------------------
package i2cdw_pkg;

   localparam int StepW = 5;
   localparam int CountW = 8;
   localparam int ByteW = 8;
   localparam int PaddrW = 3;
   localparam int PdataW = 32;

   typedef logic [StepW-1:0] step_type;
   typedef logic [ByteW-1:0] byte_type;

   localparam step_type STEP_IDLE = 5'd0;
   localparam step_type STEP_START0 = 5'd1;
   localparam step_type STEP_START1 = 5'd2;
   localparam step_type STEP_BYTE0 = 5'd3;
   localparam step_type STEP_BYTE_LAST = 5'd20;
   localparam step_type STEP_STOP0 = 5'd21;
   localparam step_type STEP_STOP1 = 5'd22;
   localparam step_type STEP_STOP2 = 5'd23;

   localparam byte_type CTRL_CMD = 8'h00;
   localparam byte_type CTRL_DATA = 8'h40;
   localparam byte_type ADDR_RESET = 8'h78;
   localparam byte_type TPP_RESET = 8'h01;

   localparam logic [1:0] SEL_ADDR = 2'd0;
   localparam logic [1:0] SEL_CTRL = 2'd1;
   localparam logic [1:0] SEL_PAYLOAD = 2'd2;

   localparam logic REG_ADDRESS = 1'b0;
   localparam logic REG_TICKS = 1'b1;

   // phase offset inside a byte at which the ack slot follows the 8 data bits
   localparam logic [4:0] ACK_PHASE0 = 5'd16;

endpackage

// ===== sv/i2c_display_write_master_top.sv =====
// ----------------------------------------------------------------------------
// i2c_display_write_master_top
// A word passes through the input register and then the result register.
// Throughput: one word per cycle while rsp_stall is low; the input register and
// result register decouple the two channels, one sequencer tick is evaluated per word.
// Reset: synchronous, active high; clears the sequencer, its nack flag and the
// valids, and loads address byte 0x78 and one tick per phase.
// ----------------------------------------------------------------------------
module i2c_display_write_master_top (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic req_req_valid,
   input  logic req_is_data,
   input  logic [7:0] req_byte,
   input  logic req_sda_in,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic rsp_scl_level,
   output logic rsp_sda_level,
   output logic rsp_sda_drive,
   output logic rsp_req_accepted,
   output logic rsp_busy_res,
   output logic rsp_done_res,
   output logic rsp_nack_seen,
   input  logic csr_psel,
   input  logic csr_penable,
   input  logic csr_pwrite,
   input  logic [i2cdw_pkg::PaddrW-1:0] csr_paddr,
   input  logic [i2cdw_pkg::PdataW-1:0] csr_pwdata,
   output logic [i2cdw_pkg::PdataW-1:0] csr_prdata,
   output logic csr_pready
);
   import i2cdw_pkg::*;

   // config registers
   byte_type addr_byte_ff, addr_byte_in;
   byte_type tpp_ff, tpp_in;
   logic csr_wr;

   // input register
   logic s1_valid_ff, s1_valid_in;
   logic s1_go_ff, s1_data_ff, s1_sda_ff;
   byte_type s1_byte_ff;
   logic take_in, adv;

   // sequencer state
   step_type step_ff, step_in;
   logic [CountW-1:0] count_ff, count_in;
   byte_type shift_ff, shift_in;
   logic [1:0] sel_ff, sel_in;
   byte_type payload_ff, payload_in;
   logic mode_ff, mode_in;
   logic nack_ff, nack_in;

   // result register
   logic rsp_valid_ff, rsp_valid_in;
   logic scl_ff, scl_in, sda_ff, sda_in_lvl, drive_ff, drive_in;
   logic acc_ff, acc_in, busy_ff, busy_in, done_ff, done_in;

   // combinational working values
   logic idle, start, last;
   step_type step_cur;
   logic [4:0] pos;
   logic [CountW:0] count_inc;
   byte_type tpp_eff;

   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = (csr_paddr[2] == REG_TICKS) ? {24'd0, tpp_ff} : {24'd0, addr_byte_ff};

   always_comb begin
      addr_byte_in = addr_byte_ff;
      tpp_in = tpp_ff;
      if (csr_wr) begin
         if (csr_paddr[2] == REG_ADDRESS) begin
            addr_byte_in = csr_pwdata[7:0];
         end else begin
            tpp_in = csr_pwdata[7:0];
         end
      end
   end

   assign adv = !rsp_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !adv;
   assign take_in = req_valid && !req_stall;
   assign s1_valid_in = take_in || (s1_valid_ff && !adv);
   assign rsp_valid_in = adv ? s1_valid_ff : rsp_valid_ff;

   always_comb begin
      step_in = step_ff;
      count_in = count_ff;
      shift_in = shift_ff;
      sel_in = sel_ff;
      payload_in = payload_ff;
      mode_in = mode_ff;
      nack_in = nack_ff;
      scl_in = 1'b1;
      sda_in_lvl = 1'b1;
      drive_in = 1'b1;
      acc_in = 1'b0;
      busy_in = 1'b0;
      done_in = 1'b0;
      idle = (step_ff == STEP_IDLE) || (step_ff > STEP_STOP2);
      start = idle && s1_go_ff;
      tpp_eff = (tpp_ff == '0) ? 8'd1 : tpp_ff;
      step_cur = idle ? (start ? STEP_START0 : STEP_IDLE) : step_ff;
      if (start) begin
         count_in = '0;
         shift_in = addr_byte_ff;
         sel_in = SEL_ADDR;
         payload_in = s1_byte_ff;
         mode_in = s1_data_ff;
         nack_in = 1'b0;
         acc_in = 1'b1;
      end
      step_in = step_cur;
      count_inc = {1'b0, count_in} + 9'd1;
      last = count_inc >= {1'b0, tpp_eff};
      pos = step_cur - STEP_BYTE0;
      if (step_cur != STEP_IDLE) begin
         busy_in = 1'b1;
         if (step_cur == STEP_START0) begin
            scl_in = 1'b1;
            sda_in_lvl = 1'b1;
         end else if (step_cur == STEP_START1) begin
            scl_in = 1'b1;
            sda_in_lvl = 1'b0;
         end else if (step_cur <= STEP_BYTE_LAST) begin
            scl_in = pos[0];
            if (pos < ACK_PHASE0) begin
               sda_in_lvl = shift_in[7];
            end else begin
               sda_in_lvl = 1'b1;
               drive_in = 1'b0;
               if (pos[0] && last && s1_sda_ff) begin
                  nack_in = 1'b1;
               end
            end
         end else if (step_cur == STEP_STOP0) begin
            scl_in = 1'b0;
            sda_in_lvl = 1'b0;
         end else if (step_cur == STEP_STOP1) begin
            scl_in = 1'b1;
            sda_in_lvl = 1'b0;
         end else begin
            scl_in = 1'b1;
            sda_in_lvl = 1'b1;
            done_in = last;
         end
         if (last) begin
            count_in = '0;
            if (step_cur >= STEP_BYTE0 && step_cur < STEP_BYTE_LAST) begin
               if (pos[0] && pos < ACK_PHASE0) begin
                  shift_in = {shift_in[6:0], 1'b0};
               end
               step_in = step_cur + 5'd1;
            end else if (step_cur == STEP_BYTE_LAST) begin
               priority if (sel_in == SEL_ADDR) begin
                  sel_in = SEL_CTRL;
                  shift_in = mode_in ? CTRL_DATA : CTRL_CMD;
                  step_in = STEP_BYTE0;
               end else if (sel_in == SEL_CTRL) begin
                  sel_in = SEL_PAYLOAD;
                  shift_in = payload_in;
                  step_in = STEP_BYTE0;
               end else begin
                  step_in = STEP_STOP0;
               end
            end else if (step_cur >= STEP_STOP2) begin
               step_in = STEP_IDLE;
            end else begin
               step_in = step_cur + 5'd1;
            end
         end else begin
            count_in = count_inc[CountW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_byte_ff <= ADDR_RESET;
         tpp_ff <= TPP_RESET;
         s1_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         step_ff <= STEP_IDLE;
         count_ff <= '0;
         shift_ff <= '0;
         sel_ff <= SEL_ADDR;
         payload_ff <= '0;
         mode_ff <= 1'b0;
         nack_ff <= 1'b0;
      end else begin
         addr_byte_ff <= addr_byte_in;
         tpp_ff <= tpp_in;
         s1_valid_ff <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (adv && s1_valid_ff) begin
            step_ff <= step_in;
            count_ff <= count_in;
            shift_ff <= shift_in;
            sel_ff <= sel_in;
            payload_ff <= payload_in;
            mode_ff <= mode_in;
            nack_ff <= nack_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (take_in) begin
         s1_go_ff <= req_req_valid;
         s1_data_ff <= req_is_data;
         s1_byte_ff <= req_byte;
         s1_sda_ff <= req_sda_in;
      end
      if (adv && s1_valid_ff) begin
         scl_ff <= scl_in;
         sda_ff <= sda_in_lvl;
         drive_ff <= drive_in;
         acc_ff <= acc_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_scl_level = scl_ff;
   assign rsp_sda_level = sda_ff;
   assign rsp_sda_drive = drive_ff;
   assign rsp_req_accepted = acc_ff;
   assign rsp_busy_res = busy_ff;
   assign rsp_done_res = done_ff;
   assign rsp_nack_seen = nack_ff;

endmodule

// ===== dv/tb_i2c_display_write_master_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_i2c_display_write_master_top
// Tick-level check of the display write master. Tick words come from a queue
// and pass through a driver with random gaps. A bit-accurate bus sequencer
// model predicts the line levels and status of every tick. A monitor with
// random stalls compares each result word against the oldest prediction.
// The address and phase length registers are rewritten between sections. This
// covers zero and maximum phase lengths, and changes that land while a bus
// transaction is in progress.
// ----------------------------------------------------------------------------
module tb_i2c_display_write_master_top;
   import i2cdw_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam logic [PaddrW-1:0] ADDR_DEVICE = {REG_ADDRESS, 2'b00};
   localparam logic [PaddrW-1:0] ADDR_TICKS = {REG_TICKS, 2'b00};

   typedef struct {
      logic rq;
      logic is_data;
      byte_type payload;
      logic sda_in;
   } tick_word_type;

   typedef struct packed {
      logic scl;
      logic sda;
      logic drive;
      logic accepted;
      logic busy;
      logic done;
      logic nack;
   } bus_levels_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_req_valid = 1'b0;
   logic req_is_data = 1'b0;
   logic [7:0] req_byte = 8'h00;
   logic req_sda_in = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_scl_level;
   logic rsp_sda_level;
   logic rsp_sda_drive;
   logic rsp_req_accepted;
   logic rsp_busy_res;
   logic rsp_done_res;
   logic rsp_nack_seen;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [PaddrW-1:0] csr_paddr = '0;
   logic [PdataW-1:0] csr_pwdata = '0;
   logic [PdataW-1:0] csr_prdata;
   logic csr_pready;

   // bus sequencer model state and register copies
   step_type seq_step;
   logic [CountW-1:0] phase_count;
   byte_type shift_reg;
   logic [1:0] byte_sel;
   byte_type payload_reg;
   logic data_mode;
   logic nack_flag;
   byte_type cfg_address;
   byte_type cfg_ticks;

   tick_word_type pending_ticks[$];
   bus_levels_type expected_levels[$];
   int unsigned words_queued = 0;
   int unsigned words_sent = 0;
   int unsigned words_checked = 0;
   int unsigned error_count = 0;
   int unsigned cycle_count = 0;
   logic quiet;

   i2c_display_write_master_top DUT (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   assign quiet = (words_sent >= 400) && (words_sent < 600);

   function automatic bus_levels_type predict_bus_tick(input logic rq, input logic is_data,
                                                       input byte_type payload,
                                                       input logic sda_in);
      bus_levels_type lv;
      logic [8:0] phase_len;
      logic last;
      step_type p;
      lv = '0;
      lv.scl = 1'b1;
      lv.sda = 1'b1;
      lv.drive = 1'b1;
      phase_len = (cfg_ticks == 8'd0) ? 9'd1 : {1'b0, cfg_ticks};
      if (seq_step == STEP_IDLE || seq_step > STEP_STOP2) begin
         seq_step = STEP_IDLE;
         if (rq) begin
            seq_step = STEP_START0;
            phase_count = '0;
            shift_reg = cfg_address;
            byte_sel = SEL_ADDR;
            payload_reg = payload;
            data_mode = is_data;
            nack_flag = 1'b0;
            lv.accepted = 1'b1;
         end
      end
      if (seq_step != STEP_IDLE) begin
         lv.busy = 1'b1;
         last = ({1'b0, phase_count} + 9'd1) >= phase_len;
         p = seq_step - STEP_BYTE0;
         if (seq_step == STEP_START0) begin
            lv.scl = 1'b1;
            lv.sda = 1'b1;
         end else if (seq_step == STEP_START1) begin
            lv.scl = 1'b1;
            lv.sda = 1'b0;
         end else if (seq_step <= STEP_BYTE_LAST) begin
            lv.scl = p[0];
            if (p < ACK_PHASE0) begin
               lv.sda = shift_reg[7];
            end else begin
               lv.sda = 1'b1;
               lv.drive = 1'b0;
               if (lv.scl && last && sda_in) nack_flag = 1'b1;
            end
         end else if (seq_step == STEP_STOP0) begin
            lv.scl = 1'b0;
            lv.sda = 1'b0;
         end else if (seq_step == STEP_STOP1) begin
            lv.scl = 1'b1;
            lv.sda = 1'b0;
         end else begin
            lv.scl = 1'b1;
            lv.sda = 1'b1;
            lv.done = last;
         end
         if (!last) begin
            phase_count = phase_count + 1'b1;
         end else begin
            phase_count = '0;
            if (seq_step >= STEP_BYTE0 && seq_step < STEP_BYTE_LAST) begin
               if (p[0] && p < ACK_PHASE0) shift_reg = shift_reg << 1;
               seq_step = seq_step + 1'b1;
            end else if (seq_step == STEP_BYTE_LAST) begin
               unique case (byte_sel)
                  SEL_ADDR: begin
                     byte_sel = SEL_CTRL;
                     shift_reg = data_mode ? CTRL_DATA : CTRL_CMD;
                     seq_step = STEP_BYTE0;
                  end
                  SEL_CTRL: begin
                     byte_sel = SEL_PAYLOAD;
                     shift_reg = payload_reg;
                     seq_step = STEP_BYTE0;
                  end
                  default: seq_step = STEP_STOP0;
               endcase
            end else if (seq_step >= STEP_STOP2) begin
               seq_step = STEP_IDLE;
            end else begin
               seq_step = seq_step + 1'b1;
            end
         end
      end
      lv.nack = nack_flag;
      return lv;
   endfunction

   // driver
   always @(posedge clock) begin
      tick_word_type w;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_levels.push_back(predict_bus_tick(req_req_valid, req_is_data,
                                                       req_byte, req_sda_in));
            words_sent++;
         end
         if (!req_valid || !req_stall) begin
            if (pending_ticks.size() != 0 && (quiet || $urandom_range(99) >= 27)) begin
               w = pending_ticks.pop_front();
               req_valid <= 1'b1;
               req_req_valid <= w.rq;
               req_is_data <= w.is_data;
               req_byte <= w.payload;
               req_sda_in <= w.sda_in;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   task automatic check_level(input string name, input logic want, input logic got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0b, actual %0b", $time, name, want, got);
         error_count++;
      end
   endtask

   // monitor
   always @(posedge clock) begin
      bus_levels_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_levels.size() == 0) begin
               $display("%0t: unexpected result word, expected none, actual %b", $time,
                        {rsp_scl_level, rsp_sda_level, rsp_sda_drive, rsp_req_accepted,
                         rsp_busy_res, rsp_done_res, rsp_nack_seen});
               error_count++;
            end else begin
               want = expected_levels.pop_front();
               check_level("scl_level", want.scl, rsp_scl_level);
               check_level("sda_level", want.sda, rsp_sda_level);
               check_level("sda_drive", want.drive, rsp_sda_drive);
               check_level("req_accepted", want.accepted, rsp_req_accepted);
               check_level("busy_res", want.busy, rsp_busy_res);
               check_level("done_res", want.done, rsp_done_res);
               check_level("nack_seen", want.nack, rsp_nack_seen);
               words_checked++;
            end
         end
         rsp_stall <= !quiet && ($urandom_range(99) < 27);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic csr_write(input logic [PaddrW-1:0] addr, input byte_type data);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= {{(PdataW-ByteW){1'b0}}, data};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (addr == ADDR_DEVICE) cfg_address = data;
      else cfg_ticks = data;
   endtask

   task automatic set_bus(input byte_type address, input byte_type ticks);
      csr_write(ADDR_DEVICE, address);
      csr_write(ADDR_TICKS, ticks);
   endtask

   task automatic push_tick(input logic rq, input logic is_data, input byte_type payload,
                            input logic sda_in);
      tick_word_type w;
      w.rq = rq;
      w.is_data = is_data;
      w.payload = payload;
      w.sda_in = sda_in;
      pending_ticks.push_back(w);
      words_queued++;
   endtask

   task automatic push_random_ticks(input int count, input int req_pct, input int nack_pct);
      for (int i = 0; i < count; i++)
         push_tick($urandom_range(99) < req_pct, 1'($urandom_range(1)),
                   8'($urandom_range(255)), $urandom_range(99) < nack_pct);
   endtask

   // sender holds off until every result word is back
   task automatic drain();
      while (words_checked != words_queued) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   initial begin
      seq_step = STEP_IDLE;
      phase_count = '0;
      shift_reg = '0;
      byte_sel = SEL_ADDR;
      payload_reg = '0;
      data_mode = 1'b0;
      nack_flag = 1'b0;
      cfg_address = ADDR_RESET;
      cfg_ticks = TPP_RESET;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // reset settings: all-ones data transaction, requests while busy, nack on first ack
      push_tick(1'b1, 1'b1, 8'hFF, 1'b0);
      for (int i = 1; i < 25; i++)
         push_tick(1'b1, 1'b0, 8'h00, i == 19);
      drain();

      // zero phase length, written while the transaction is still running
      set_bus(8'h00, 8'h00);
      push_random_ticks(200, 40, 10);
      drain();
      set_bus(8'hFF, 8'h01);
      push_random_ticks(200, 60, 5);
      drain();
      set_bus(8'($urandom_range(255)), 8'h02);
      push_random_ticks(150, 50, 10);
      drain();
      set_bus(8'($urandom_range(255)), 8'hFF);
      push_random_ticks(100, 50, 20);
      drain();
      // long phase cut short
      set_bus(8'hA5, 8'h01);
      push_random_ticks(150, 30, 10);
      drain();
      set_bus(8'($urandom_range(255)), 8'($urandom_range(1, 4)));
      push_random_ticks(150, 50, 10);
      drain();

      repeat (10) @(posedge clock);
      if (error_count == 0 && expected_levels.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
